[sv/tcw_pkg.sv]
`timescale 1ns / 1ps

package tcw_pkg;

	// Operation codes on the op port
	localparam logic [2:0] OP_PUT_CHAR     = 3'd0;
	localparam logic [2:0] OP_WRITE_CELL   = 3'd1;
	localparam logic [2:0] OP_SET_CURSOR   = 3'd2;
	localparam logic [2:0] OP_CLEAR_SCREEN = 3'd3;
	localparam logic [2:0] OP_CLEAR_ROW    = 3'd4;
	localparam logic [2:0] OP_READ_CELL    = 3'd5;

	// Character and attribute constants
	localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
	localparam logic [7:0] BLANK_CHAR   = 8'h20;
	localparam logic [7:0] BLANK_ATTR   = 8'h0F;

	// Command kinds after decode in the front
	typedef enum logic [2:0] {
		K_PUT,
		K_NEWLINE,
		K_WRITE,
		K_SET,
		K_CLR_SCREEN,
		K_CLR_ROW,
		K_READ,
		K_NOP
	} tcw_kind_t;

	// Back sequencer states
	typedef enum logic [2:0] {
		B_IDLE,
		B_READ,
		B_BLANK,
		B_CLEAR,
		B_DONE
	} tcw_state_t;

	// Decoded command passed from front to back
	typedef struct packed {
		tcw_kind_t  kind;
		logic [7:0] ch;
		logic [7:0] attr;
		logic [6:0] col;
		logic [4:0] row;
	} tcw_cmd_t;

	// Result item as stored in the result queue
	typedef struct packed {
		logic [6:0] cursor_col;
		logic [4:0] cursor_row;
		logic [7:0] cell_char;
		logic [7:0] cell_attr;
		logic       scrolled;
	} tcw_res_t;

endpackage

[sv/tcw_fifo.sv]
`timescale 1ns / 1ps

module tcw_fifo
	#(
		parameter int WIDTH = 31,
		parameter int DEPTH = 2
	)
	(
		input  logic             clk,
		input  logic             arst_n,
		input  logic             push,
		input  logic [WIDTH-1:0] wdata,
		output logic             full,
		input  logic             pop,
		output logic [WIDTH-1:0] rdata,
		output logic             empty
	);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store the incoming item
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

[sv/tcw_front.sv]
`timescale 1ns / 1ps

module tcw_front
	import tcw_pkg::*;
	#(
		parameter int COLUMNS = 80,
		parameter int ROWS    = 25
	)
	(
		input  logic [2:0] op,
		input  logic [7:0] char_code,
		input  logic [7:0] attribute,
		input  logic [6:0] column,
		input  logic [4:0] row,
		output tcw_cmd_t   cmd
	);

	logic col_ok;
	logic row_ok;

	assign col_ok = (int'(column) < COLUMNS);
	assign row_ok = (int'(row) < ROWS);

	// Classify the item; drop out-of-range cell and row accesses to no-ops
	always_comb begin
		cmd.ch   = char_code;
		cmd.attr = attribute;
		cmd.col  = column;
		cmd.row  = row;
		unique case (op)
			OP_PUT_CHAR: begin
				cmd.kind = (char_code == NEWLINE_CHAR) ? K_NEWLINE : K_PUT;
			end
			OP_WRITE_CELL: begin
				cmd.kind = (col_ok && row_ok) ? K_WRITE : K_NOP;
			end
			OP_SET_CURSOR: begin
				cmd.kind = K_SET;
				// Saturate the cursor at the last column and row
				if (!col_ok) begin
					cmd.col = 7'(COLUMNS - 1);
				end
				if (!row_ok) begin
					cmd.row = 5'(ROWS - 1);
				end
			end
			OP_CLEAR_SCREEN: begin
				cmd.kind = K_CLR_SCREEN;
			end
			OP_CLEAR_ROW: begin
				cmd.kind = row_ok ? K_CLR_ROW : K_NOP;
			end
			OP_READ_CELL: begin
				cmd.kind = (col_ok && row_ok) ? K_READ : K_NOP;
			end
			default: begin
				cmd.kind = K_NOP;
			end
		endcase
	end

endmodule

[sv/tcw_back.sv]
`timescale 1ns / 1ps

module tcw_back
	import tcw_pkg::*;
	#(
		parameter int COLUMNS = 80,
		parameter int ROWS    = 25
	)
	(
		input  logic     clk,
		input  logic     arst_n,
		input  logic     cmd_empty,
		input  tcw_cmd_t cmd,
		output logic     cmd_pop,
		input  logic     res_full,
		output logic     res_push,
		output tcw_res_t res,
		output logic     init_busy
	);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int SUM_W  = ROW_W + 1;

	tcw_state_t        state_q, state_d;
	logic [COL_W-1:0]  cur_col_q, cur_col_d;
	logic [ROW_W-1:0]  cur_row_q, cur_row_d;
	logic [ROW_W-1:0]  base_q, base_d;
	logic [ADDR_W-1:0] cnt_q, cnt_d;
	logic [ADDR_W-1:0] sweep_base_q, sweep_base_d;
	logic [7:0]        sweep_attr_q, sweep_attr_d;
	logic              init_q, init_d;
	logic [7:0]        rd_char_q, rd_char_d;
	logic [7:0]        rd_attr_q, rd_attr_d;
	logic              scrolled_q, scrolled_d;

	logic [15:0]       mem [CELLS];
	logic [15:0]       rdata_q;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [15:0]       mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;

	logic [ADDR_W-1:0] cur_addr;
	logic [ADDR_W-1:0] cmd_addr;
	logic [ROW_W-1:0]  base_next;

	// Map a screen row through the scroll offset to the first cell of its physical row
	function automatic logic [ADDR_W-1:0] row_base(input logic [ROW_W-1:0] r,
			input logic [ROW_W-1:0] b);
		logic [SUM_W-1:0] s;
		s = {1'b0, r} + {1'b0, b};
		if (s >= SUM_W'(ROWS)) begin
			s = s - SUM_W'(ROWS);
		end
		return ADDR_W'(int'(s) * COLUMNS);
	endfunction

	assign cur_addr  = row_base(cur_row_q, base_q) + ADDR_W'(cur_col_q);
	assign cmd_addr  = row_base(ROW_W'(cmd.row), base_q) + ADDR_W'(cmd.col);
	assign base_next = (base_q == ROW_W'(ROWS - 1)) ? '0 : base_q + 1'b1;

	assign init_busy           = init_q;
	assign res.cursor_col      = 7'(cur_col_q);
	assign res.cursor_row      = 5'(cur_row_q);
	assign res.cell_char       = rd_char_q;
	assign res.cell_attr       = rd_attr_q;
	assign res.scrolled        = scrolled_q;

	// Sequence each command: next state, register updates and memory strobes
	always_comb begin
		state_d      = state_q;
		cur_col_d    = cur_col_q;
		cur_row_d    = cur_row_q;
		base_d       = base_q;
		cnt_d        = cnt_q;
		sweep_base_d = sweep_base_q;
		sweep_attr_d = sweep_attr_q;
		init_d       = init_q;
		rd_char_d    = rd_char_q;
		rd_attr_d    = rd_attr_q;
		scrolled_d   = scrolled_q;
		cmd_pop      = 1'b0;
		res_push     = 1'b0;
		mem_we       = 1'b0;
		mem_waddr    = '0;
		mem_wdata    = '0;
		mem_re       = 1'b0;
		mem_raddr    = '0;
		unique case (state_q)
			B_IDLE: begin
				// Take a command only when its result has room
				if (!cmd_empty && !res_full) begin
					cmd_pop    = 1'b1;
					rd_char_d  = '0;
					rd_attr_d  = '0;
					scrolled_d = 1'b0;
					state_d    = B_DONE;
					unique case (cmd.kind)
						K_PUT, K_NEWLINE: begin
							if (cmd.kind == K_PUT) begin
								mem_we    = 1'b1;
								mem_waddr = cur_addr;
								mem_wdata = {cmd.attr, cmd.ch};
							end
							if (cmd.kind == K_PUT && cur_col_q != COL_W'(COLUMNS - 1)) begin
								cur_col_d = cur_col_q + 1'b1;
							end else if (cur_row_q != ROW_W'(ROWS - 1)) begin
								cur_col_d = '0;
								cur_row_d = cur_row_q + 1'b1;
							end else begin
								// Scroll: rotate the offset, blank the old top row
								cur_col_d    = '0;
								base_d       = base_next;
								scrolled_d   = 1'b1;
								sweep_base_d = row_base('0, base_q);
								sweep_attr_d = BLANK_ATTR;
								cnt_d        = '0;
								state_d      = B_BLANK;
							end
						end
						K_WRITE: begin
							mem_we    = 1'b1;
							mem_waddr = cmd_addr;
							mem_wdata = {cmd.attr, cmd.ch};
						end
						K_SET: begin
							cur_col_d = COL_W'(cmd.col);
							cur_row_d = ROW_W'(cmd.row);
						end
						K_CLR_SCREEN: begin
							sweep_attr_d = cmd.attr;
							cnt_d        = '0;
							state_d      = B_CLEAR;
						end
						K_CLR_ROW: begin
							sweep_base_d = row_base(ROW_W'(cmd.row), base_q);
							sweep_attr_d = BLANK_ATTR;
							cnt_d        = '0;
							state_d      = B_BLANK;
						end
						K_READ: begin
							mem_re    = 1'b1;
							mem_raddr = cmd_addr;
							state_d   = B_READ;
						end
						K_NOP: begin
						end
					endcase
				end
			end
			B_READ: begin
				rd_char_d = rdata_q[7:0];
				rd_attr_d = rdata_q[15:8];
				state_d   = B_DONE;
			end
			B_BLANK: begin
				// Blank one cell of the row per cycle
				mem_we    = 1'b1;
				mem_waddr = sweep_base_q + cnt_q;
				mem_wdata = {sweep_attr_q, BLANK_CHAR};
				if (cnt_q == ADDR_W'(COLUMNS - 1)) begin
					state_d = B_DONE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			B_CLEAR: begin
				// Blank every cell in physical order
				mem_we    = 1'b1;
				mem_waddr = cnt_q;
				mem_wdata = {sweep_attr_q, BLANK_CHAR};
				if (cnt_q == ADDR_W'(CELLS - 1)) begin
					init_d  = 1'b0;
					state_d = init_q ? B_IDLE : B_DONE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			B_DONE: begin
				res_push = 1'b1;
				state_d  = B_IDLE;
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// Hold state; reset starts the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_CLEAR;
			init_q       <= 1'b1;
			cnt_q        <= '0;
			sweep_attr_q <= BLANK_ATTR;
			cur_col_q    <= '0;
			cur_row_q    <= '0;
			base_q       <= '0;
		end else begin
			state_q      <= state_d;
			init_q       <= init_d;
			cnt_q        <= cnt_d;
			sweep_attr_q <= sweep_attr_d;
			cur_col_q    <= cur_col_d;
			cur_row_q    <= cur_row_d;
			base_q       <= base_d;
		end
	end

	// Result fields and sweep base
	always_ff @(posedge clk) begin
		sweep_base_q <= sweep_base_d;
		rd_char_q    <= rd_char_d;
		rd_attr_q    <= rd_attr_d;
		scrolled_q   <= scrolled_d;
	end

	// Cell store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

endmodule

[sv/text_console_writer.sv]
// Before it shows on the result ports, an item passes the command queue, the back sequencer's
// idle and done states and the result queue; read_cell adds the read state, a scrolling put_char
// and clear_row add the blanking state for one row, and clear_screen the clearing state for all.
// The back sequencer finishes each command before it takes the next. Scrolling rotates a row
// offset, so it only blanks one row of the cell store. Reset (arst_n low, asynchronous) starts a
// clearing pass that blanks every cell with attribute 0x0F; full stays high until it ends.
`timescale 1ns / 1ps

module text_console_writer
	import tcw_pkg::*;
	#(
		parameter int COLUMNS = 80,
		parameter int ROWS    = 25
	)
	(
		input  logic       clk,
		input  logic       arst_n,
		input  logic       push,
		output logic       full,
		input  logic [2:0] op,
		input  logic [7:0] char_code,
		input  logic [7:0] attribute,
		input  logic [6:0] column,
		input  logic [4:0] row,
		input  logic       pop,
		output logic       empty,
		output logic [6:0] cursor_col,
		output logic [4:0] cursor_row,
		output logic [7:0] cell_char,
		output logic [7:0] cell_attr,
		output logic       scrolled
	);

	tcw_cmd_t front_cmd;
	tcw_cmd_t back_cmd;
	logic     cmd_full;
	logic     cmd_empty;
	logic     cmd_pop;
	logic     init_busy;
	logic     res_full;
	logic     res_push;
	tcw_res_t back_res;
	tcw_res_t out_res;

	assign full = cmd_full | init_busy;

	// Decode the incoming item
	tcw_front #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_front (
		.op       (op),
		.char_code(char_code),
		.attribute(attribute),
		.column   (column),
		.row      (row),
		.cmd      (front_cmd)
	);

	// Queue decoded commands
	tcw_fifo #(
		.WIDTH($bits(tcw_cmd_t)),
		.DEPTH(2)
	) u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push & ~full),
		.wdata (front_cmd),
		.full  (cmd_full),
		.pop   (cmd_pop),
		.rdata (back_cmd),
		.empty (cmd_empty)
	);

	// Execute commands against the cell store
	tcw_back #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmd_empty),
		.cmd      (back_cmd),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (back_res),
		.init_busy(init_busy)
	);

	// Queue results for the consumer
	tcw_fifo #(
		.WIDTH($bits(tcw_res_t)),
		.DEPTH(2)
	) u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (back_res),
		.full  (res_full),
		.pop   (pop),
		.rdata (out_res),
		.empty (empty)
	);

	assign cursor_col = out_res.cursor_col;
	assign cursor_row = out_res.cursor_row;
	assign cell_char  = out_res.cell_char;
	assign cell_attr  = out_res.cell_attr;
	assign scrolled   = out_res.scrolled;

endmodule

[sv/tcw_checker.sv]
`timescale 1ns / 1ps

module tcw_checker
	#(
		parameter int COLUMNS = 80,
		parameter int ROWS    = 25
	)
	(
		input logic       clk,
		input logic       arst_n,
		input logic       empty,
		input logic       pop,
		input logic [6:0] cursor_col,
		input logic [4:0] cursor_row,
		input logic       scrolled
	);

	// Reported cursor stays on the screen
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (int'(cursor_col) < COLUMNS))
		else $error("cursor column beyond the screen");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (int'(cursor_row) < ROWS))
		else $error("cursor row beyond the screen");

	// A scroll leaves the cursor at the start of the last row
	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && scrolled) |-> (cursor_col == 7'd0 && cursor_row == 5'(ROWS - 1)))
		else $error("scroll left the cursor off the last row start");

	// A waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(cursor_col) && $stable(cursor_row)
			&& $stable(scrolled)))
		else $error("waiting result changed before pop");

endmodule

bind text_console_writer tcw_checker #(
	.COLUMNS(COLUMNS),
	.ROWS   (ROWS)
) u_tcw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.empty     (empty),
	.pop       (pop),
	.cursor_col(cursor_col),
	.cursor_row(cursor_row),
	.scrolled  (scrolled)
);
